/* hdl/cda_pkg.sv */
package cda_pkg;

	localparam int CDA_YEAR_BITS  = 16;
	localparam int CDA_AMOUNT_W   = 16;
	localparam int CDA_STRIDE_W   = 10;
	localparam int CDA_DAY_W      = 5;
	localparam int CDA_MONTH_W    = 4;
	localparam int CDA_LYEAR_W    = 16;
	localparam int CDA_RES_W      = 9;
	localparam int CDA_RESET_YEAR = 2000;
	localparam int CDA_CYCLE      = 400;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_DAYS   = 2'd1,
		OP_MONTHS = 2'd2,
		OP_YEARS  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LMOD,
		ST_LCHK,
		ST_RUN,
		ST_DONE
	} state_t;

	// Reduces a value below three times the 400-year cycle to its residue.
	function automatic logic [CDA_RES_W-1:0] mod400_small(input logic [10:0] v);
		logic [10:0] r;
		begin
			if (v >= 11'd800) begin
				r = v - 11'd800;
			end else if (v >= 11'd400) begin
				r = v - 11'd400;
			end else begin
				r = v;
			end
			return r[CDA_RES_W-1:0];
		end
	endfunction

	// Leap test from the two low year bits and the year's residue modulo 400.
	function automatic logic is_leap(input logic [1:0] ylow, input logic [CDA_RES_W-1:0] res);
		return (ylow == 2'd0) && (res != 9'd100) && (res != 9'd200) && (res != 9'd300);
	endfunction

	function automatic logic [CDA_DAY_W-1:0] days_in(input logic [CDA_MONTH_W-1:0] m,
			input logic leap);
		logic [CDA_DAY_W-1:0] d;
		begin
			case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11:                  d = 5'd30;
				4'd2:                                     d = leap ? 5'd29 : 5'd28;
				default:                                  d = 5'd0;
			endcase
			return d;
		end
	endfunction

endpackage

/* hdl/calendar_date_adder_core.sv */
// Gregorian date register with date arithmetic.
//
// Input channel (in_valid / in_stall) carries one command: load a date, or add
// amount days, amount months, or amount steps of year_stride years. Output
// channel (out_valid / out_stall) returns one result per command: the date
// held after it, with load_error set when a load was rejected as invalid.
//
// One command is in work at a time; in_stall is high from the transfer until
// the result has been placed in the output register. An add command makes
// one day, month or year step per cycle through the shared year adder and
// its modulo-400 residue, then writes the result. A load first takes the
// modulo-400 residue of the loaded year, then makes the validity check and
// then writes the result. The result is shown from the next cycle and the
// next command may be taken while it still waits; a stalled receiver only
// holds back the command after that one.
//
// Reset sets the date to 1 January 2000 and empties the output register.
module calendar_date_adder_core
	import cda_pkg::*;
#(
	parameter int YEAR_BITS = CDA_YEAR_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              op,
	input  logic [CDA_AMOUNT_W-1:0] amount,
	input  logic [CDA_STRIDE_W-1:0] year_stride,
	input  logic [CDA_DAY_W-1:0]    load_day,
	input  logic [CDA_MONTH_W-1:0]  load_month,
	input  logic [CDA_LYEAR_W-1:0]  load_year,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CDA_DAY_W-1:0]    day_out,
	output logic [CDA_MONTH_W-1:0]  month_out,
	output logic [CDA_LYEAR_W-1:0]  year_out,
	output logic                    load_error
);

	localparam logic [CDA_RES_W-1:0] WRAP_RES =
		CDA_RES_W'((64'd1 << YEAR_BITS) % 64'd400);
	localparam logic [CDA_RES_W-1:0] WRAP_ADJ = CDA_RES_W'(CDA_CYCLE) - WRAP_RES;
	localparam logic [CDA_LYEAR_W-1:0] LY_MASK = (YEAR_BITS >= CDA_LYEAR_W) ?
		{CDA_LYEAR_W{1'b1}} : CDA_LYEAR_W'((64'd1 << YEAR_BITS) - 64'd1);
	localparam logic [CDA_RES_W-1:0] RST_RES = CDA_RES_W'(CDA_RESET_YEAR % CDA_CYCLE);
	// (x * 2622) >> 16 equals x / 25 for every x below 4096.
	localparam logic [23:0] DIV25_K = 24'd2622;

	state_t state_q, state_nxt;

	logic [CDA_DAY_W-1:0]    cur_day_q;
	logic [CDA_MONTH_W-1:0]  cur_month_q;
	logic [YEAR_BITS-1:0]    cur_year_q;
	logic [CDA_RES_W-1:0]    yres_q;

	op_t                     op_q;
	logic [CDA_AMOUNT_W-1:0] cnt_q;
	logic [CDA_STRIDE_W-1:0] stride_q;
	logic [CDA_RES_W-1:0]    smod_q;
	logic [CDA_DAY_W-1:0]    ld_day_q;
	logic [CDA_MONTH_W-1:0]  ld_month_q;
	logic [CDA_LYEAR_W-1:0]  ld_year_q;
	logic [CDA_RES_W-1:0]    lres_q;
	logic [7:0]              lq_q;
	logic                    err_q;

	logic                    out_valid_q;
	logic [CDA_DAY_W-1:0]    day_out_q;
	logic [CDA_MONTH_W-1:0]  month_out_q;
	logic [CDA_LYEAR_W-1:0]  year_out_q;
	logic                    load_error_q;

	logic in_xfer, out_xfer, slot_free, done_fire;

	// Shared year adder with its residue tracking.
	logic [YEAR_BITS:0]      ysum;
	logic [YEAR_BITS-1:0]    ysum_year;
	logic [CDA_RES_W-1:0]    ysum_res;
	logic [CDA_RES_W-1:0]    add_res;
	logic                    ysum_leap;

	logic                    leap_cur, nm_wrap, mstep_leap, ld_leap, ld_bad;
	logic [CDA_MONTH_W-1:0]  nm_month;
	logic [CDA_DAY_W-1:0]    dim_cur, dim_mstep, dim_ystep, dim_ld;
	logic [CDA_LYEAR_W-1:0]  ly_in, lres_full;
	logic [23:0]             lq_prod;

	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// The year over 400 is the year over 16, then over 25.
	assign ly_in   = load_year & LY_MASK;
	assign lq_prod = {12'd0, ly_in[CDA_LYEAR_W-1:4]} * DIV25_K;

	always_comb begin
		if (op_q == OP_YEARS) begin
			ysum    = {1'b0, cur_year_q} + (YEAR_BITS+1)'(stride_q);
			add_res = smod_q;
		end else begin
			ysum    = {1'b0, cur_year_q} + (YEAR_BITS+1)'(1);
			add_res = CDA_RES_W'(1);
		end
		ysum_year = ysum[YEAR_BITS-1:0];
		// On a wrap the true sum lost 2^YEAR_BITS, so the residue takes that off too.
		ysum_res  = mod400_small(11'(yres_q) + 11'(add_res) +
			(ysum[YEAR_BITS] ? 11'(WRAP_ADJ) : 11'd0));
		ysum_leap = is_leap(ysum_year[1:0], ysum_res);
	end

	always_comb begin
		leap_cur   = is_leap(cur_year_q[1:0], yres_q);
		dim_cur    = days_in(cur_month_q, leap_cur);
		nm_wrap    = cur_month_q >= CDA_MONTH_W'(12);
		nm_month   = nm_wrap ? CDA_MONTH_W'(1) : cur_month_q + CDA_MONTH_W'(1);
		mstep_leap = nm_wrap ? ysum_leap : leap_cur;
		dim_mstep  = days_in(nm_month, mstep_leap);
		dim_ystep  = days_in(cur_month_q, ysum_leap);
		ld_leap    = is_leap(ld_year_q[1:0], lres_q);
		dim_ld     = days_in(ld_month_q, ld_leap);
		ld_bad     = (dim_ld == '0) || (ld_day_q == '0) || (ld_day_q > dim_ld);
		lres_full  = ld_year_q - CDA_LYEAR_W'(lq_q) * CDA_LYEAR_W'(CDA_CYCLE);
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_nxt = (op_t'(op) == OP_LOAD) ? ST_LMOD : ST_RUN;
				end
			end
			ST_LMOD: state_nxt = ST_LCHK;
			ST_LCHK: state_nxt = ST_DONE;
			ST_RUN: begin
				if (cnt_q == '0) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = state_q != ST_IDLE;
		done_fire = (state_q == ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_day_q   <= CDA_DAY_W'(1);
			cur_month_q <= CDA_MONTH_W'(1);
			cur_year_q  <= YEAR_BITS'(CDA_RESET_YEAR);
			yres_q      <= RST_RES;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_LCHK && !ld_bad) begin
				cur_day_q   <= ld_day_q;
				cur_month_q <= ld_month_q;
				cur_year_q  <= YEAR_BITS'(ld_year_q);
				yres_q      <= lres_q;
			end
			if (state_q == ST_RUN && cnt_q != '0) begin
				case (op_q)
					OP_DAYS: begin
						if (cur_day_q >= dim_cur) begin
							cur_day_q   <= CDA_DAY_W'(1);
							cur_month_q <= nm_month;
							if (nm_wrap) begin
								cur_year_q <= ysum_year;
								yres_q     <= ysum_res;
							end
						end else begin
							cur_day_q <= cur_day_q + CDA_DAY_W'(1);
						end
					end
					OP_MONTHS: begin
						cur_month_q <= nm_month;
						if (nm_wrap) begin
							cur_year_q <= ysum_year;
							yres_q     <= ysum_res;
						end
						if (cur_day_q > dim_mstep) begin
							cur_day_q <= dim_mstep;
						end
					end
					default: begin
						cur_year_q <= ysum_year;
						yres_q     <= ysum_res;
						if (cur_day_q > dim_ystep) begin
							cur_day_q <= dim_ystep;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q       <= op_t'(op);
			cnt_q      <= amount;
			stride_q   <= year_stride;
			smod_q     <= mod400_small(11'(year_stride));
			ld_day_q   <= load_day;
			ld_month_q <= load_month;
			ld_year_q  <= ly_in;
			lq_q       <= lq_prod[23:16];
			err_q      <= 1'b0;
		end
		if (state_q == ST_LMOD) begin
			// The remainder after taking off the whole 400-year cycles is below 400.
			lres_q <= lres_full[CDA_RES_W-1:0];
		end
		if (state_q == ST_LCHK) begin
			err_q <= ld_bad;
		end
		if (state_q == ST_RUN && cnt_q != '0) begin
			cnt_q <= cnt_q - CDA_AMOUNT_W'(1);
		end
		if (done_fire) begin
			day_out_q    <= cur_day_q;
			month_out_q  <= cur_month_q;
			year_out_q   <= CDA_LYEAR_W'(cur_year_q);
			load_error_q <= err_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign day_out    = day_out_q;
	assign month_out  = month_out_q;
	assign year_out   = year_out_q;
	assign load_error = load_error_q;

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cnt_q == '0) |=> (state_q == ST_DONE))
		else $error("add command did not finish when its count ran out");

	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_day_q != '0) && (cur_day_q <= dim_cur) && (dim_cur != '0))
		else $error("held date is not a valid calendar date");

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		yres_q < CDA_RES_W'(CDA_CYCLE))
		else $error("year residue out of range");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |=> (state_q == ST_IDLE && out_valid_q))
		else $error("finished result not placed in output register");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import cda_pkg::*;

	localparam int IDLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_CMDS = 75;

	typedef struct {
		op_t                    op;
		logic [CDA_AMOUNT_W-1:0] amount;
		logic [CDA_STRIDE_W-1:0] stride;
		logic [CDA_DAY_W-1:0]    ld;
		logic [CDA_MONTH_W-1:0]  lm;
		logic [CDA_LYEAR_W-1:0]  ly;
	} date_cmd_t;

	typedef struct {
		logic [CDA_DAY_W-1:0]   day;
		logic [CDA_MONTH_W-1:0] month;
		logic [15:0]            year;
		logic                   err;
	} date_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              op;
	logic [CDA_AMOUNT_W-1:0] amount;
	logic [CDA_STRIDE_W-1:0] year_stride;
	logic [CDA_DAY_W-1:0]    load_day;
	logic [CDA_MONTH_W-1:0]  load_month;
	logic [CDA_LYEAR_W-1:0]  load_year;
	logic                    out_valid;
	logic                    out_stall;
	logic [CDA_DAY_W-1:0]    day_out;
	logic [CDA_MONTH_W-1:0]  month_out;
	logic [CDA_LYEAR_W-1:0]  year_out;
	logic                    load_error;

	date_cmd_t pending_cmds[$];
	date_t     expected_dates[$];
	int        mismatch_count = 0;

	// Date held by the predictor, reset to 1 January 2000.
	logic [CDA_DAY_W-1:0]   date_day = 5'd1;
	logic [CDA_MONTH_W-1:0] date_month = 4'd1;
	logic [15:0]            date_year = 16'd2000;

	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned stall_timer;
	logic [1:0]  stall_mode;
	int unsigned idle_cycles;

	calendar_date_adder_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.amount      (amount),
		.year_stride (year_stride),
		.load_day    (load_day),
		.load_month  (load_month),
		.load_year   (load_year),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.day_out     (day_out),
		.month_out   (month_out),
		.year_out    (year_out),
		.load_error  (load_error)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [4:0] month_length(input logic [3:0] m, input logic [15:0] y);
		logic leap;
		leap = ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
		case (m)
			4'd2:                      return leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7,
			4'd8, 4'd10, 4'd12:        return 5'd31;
			default:                   return 5'd0;
		endcase
	endfunction

	function automatic void advance_month();
		if (date_month >= 4'd12) begin
			date_month = 4'd1;
			date_year = date_year + 16'd1;
		end else begin
			date_month = date_month + 4'd1;
		end
	endfunction

	function automatic void clamp_day();
		logic [4:0] len;
		len = month_length(date_month, date_year);
		if (date_day > len)
			date_day = len;
	endfunction

	// Applies one command to the held date and returns the date reported for it.
	function automatic date_t apply_command(input date_cmd_t c);
		date_t       r;
		int unsigned i;
		logic [4:0]  len;
		r.err = 1'b0;
		case (c.op)
			OP_LOAD: begin
				len = month_length(c.lm, c.ly);
				if (len == 5'd0 || c.ld == 5'd0 || c.ld > len) begin
					r.err = 1'b1;
				end else begin
					date_day = c.ld;
					date_month = c.lm;
					date_year = c.ly;
				end
			end
			OP_DAYS: begin
				for (i = 0; i < c.amount; i++) begin
					if (date_day >= month_length(date_month, date_year)) begin
						advance_month();
						date_day = 5'd1;
					end else begin
						date_day = date_day + 5'd1;
					end
				end
			end
			OP_MONTHS: begin
				for (i = 0; i < c.amount; i++) begin
					advance_month();
					clamp_day();
				end
			end
			default: begin
				for (i = 0; i < c.amount; i++) begin
					date_year = date_year + {6'd0, c.stride};
					clamp_day();
				end
			end
		endcase
		r.day = date_day;
		r.month = date_month;
		r.year = date_year;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic push_cmd(input op_t o, input logic [15:0] amt, input logic [9:0] strd,
			input logic [4:0] d, input logic [3:0] m, input logic [15:0] y);
		date_cmd_t c;
		c.op = o;
		c.amount = amt;
		c.stride = strd;
		c.ld = d;
		c.lm = m;
		c.ly = y;
		pending_cmds.push_back(c);
	endtask

	task automatic add_random_cmd();
		logic [3:0]  m;
		logic [15:0] y;
		logic [4:0]  d;
		logic [15:0] amt;
		logic [9:0]  strd;
		int          kind;
		int          pick;
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			// Mostly well-formed dates, biased towards month ends and century years.
			case ($urandom_range(0, 3))
				0:       y = 16'(100 * $urandom_range(0, 655));
				1:       y = 16'($urandom_range(65530, 65535));
				default: y = 16'($urandom);
			endcase
			m = 4'($urandom_range(1, 12));
			d = 5'($urandom_range(1, month_length(m, y)));
			kind = $urandom_range(0, 9);
			if (kind < 3) begin
				d = month_length(m, y);
			end else if (kind == 7) begin
				m = 4'($urandom_range(0, 3));
				if (m != 4'd0)
					m = m + 4'd12;
			end else if (kind == 8) begin
				d = 5'd0;
			end else if (kind == 9) begin
				m = $urandom_range(0, 1) ? 4'd2 : 4'd11;
				d = 5'($urandom_range(month_length(m, y) + 1, 31));
			end
			push_cmd(OP_LOAD, 16'($urandom), 10'($urandom), d, m, y);
		end else begin
			if ($urandom_range(0, 39) == 0)
				amt = 16'($urandom_range(2000, 65535));
			else if ($urandom_range(0, 7) == 0)
				amt = 16'($urandom_range(0, 2000));
			else
				amt = 16'($urandom_range(0, 40));
			if ($urandom_range(0, 9) == 0)
				strd = 10'($urandom);
			else
				strd = 10'($urandom_range(1, 1000));
			push_cmd(pick < 6 ? OP_DAYS : (pick < 8 ? OP_MONTHS : OP_YEARS), amt, strd,
				5'($urandom), 4'($urandom), 16'($urandom));
		end
	endtask

	// Command sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_LOAD;
			amount <= '0;
			year_stride <= '0;
			load_day <= '0;
			load_month <= '0;
			load_year <= '0;
			burst_left <= 1;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_dates.push_back(apply_command('{op_t'(op), amount, year_stride,
					load_day, load_month, load_year}));
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0 || pending_cmds.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left != 0)
						gap_left <= gap_left - 1;
				end else begin
					in_valid <= 1'b1;
					op <= pending_cmds[0].op;
					amount <= pending_cmds[0].amount;
					year_stride <= pending_cmds[0].stride;
					load_day <= pending_cmds[0].ld;
					load_month <= pending_cmds[0].lm;
					load_year <= pending_cmds[0].ly;
					void'(pending_cmds.pop_front());
					if (burst_left <= 1) begin
						burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
							: $urandom_range(1, 8);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// Result checker; the stall pattern switches between modes every so often.
	always @(posedge clk or negedge arst_n) begin : result_check
		date_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_timer <= 0;
			stall_mode <= 2'd0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_dates.size() == 0) begin
					report_mismatch($sformatf("result %0d/%0d/%0d with no command outstanding",
						day_out, month_out, year_out));
				end else begin
					want = expected_dates.pop_front();
					if (day_out !== want.day)
						report_mismatch($sformatf("day_out %0d, predicted %0d", day_out, want.day));
					if (month_out !== want.month)
						report_mismatch($sformatf("month_out %0d, predicted %0d",
							month_out, want.month));
					if (year_out !== want.year)
						report_mismatch($sformatf("year_out %0d, predicted %0d",
							year_out, want.year));
					if (load_error !== want.err)
						report_mismatch($sformatf("load_error %0b, predicted %0b",
							load_error, want.err));
				end
			end
			if (stall_timer == 0) begin
				stall_mode <= 2'($urandom_range(0, 3));
				stall_timer <= $urandom_range(20, 200);
				out_stall <= 1'b0;
			end else begin
				stall_timer <= stall_timer - 1;
				case (stall_mode)
					2'd0:    out_stall <= 1'b0;
					2'd1:    out_stall <= 1'($urandom_range(0, 1));
					2'd2:    out_stall <= ($urandom_range(0, 9) < 8);
					default: out_stall <= stall_timer[2];
				endcase
			end
		end
	end

	// Ends the run if neither channel has made a transfer for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int n;
		arst_n = 1'b0;

		// Leap rule at the century and quad-century years.
		push_cmd(OP_LOAD, 16'hFFFF, 10'h3FF, 5'd29, 4'd2, 16'd2000);
		push_cmd(OP_LOAD, 16'd0, 10'd0, 5'd29, 4'd2, 16'd1900);
		push_cmd(OP_LOAD, 16'd7, 10'd5, 5'd29, 4'd2, 16'd2004);
		// Rejected loads: day zero, bad months, day beyond the month.
		push_cmd(OP_LOAD, 16'hFFFF, 10'h3FF, 5'd0, 4'd5, 16'd2010);
		push_cmd(OP_LOAD, 16'd1, 10'd1, 5'd1, 4'd0, 16'd2010);
		push_cmd(OP_LOAD, 16'd1, 10'd1, 5'd1, 4'd13, 16'd2010);
		push_cmd(OP_LOAD, 16'd0, 10'd0, 5'd31, 4'd15, 16'hFFFF);
		push_cmd(OP_LOAD, 16'd0, 10'd0, 5'd31, 4'd4, 16'd2010);
		// Year wrap, and year zero treated as a leap year.
		push_cmd(OP_LOAD, 16'd0, 10'd0, 5'd31, 4'd12, 16'hFFFF);
		push_cmd(OP_DAYS, 16'd0, 10'd0, 5'h1F, 4'hF, 16'hFFFF);
		push_cmd(OP_DAYS, 16'd1, 10'd0, 5'd0, 4'd0, 16'd0);
		push_cmd(OP_LOAD, 16'd0, 10'd0, 5'd28, 4'd2, 16'd0);
		push_cmd(OP_DAYS, 16'd1, 10'h3FF, 5'h1F, 4'hF, 16'hFFFF);
		push_cmd(OP_DAYS, 16'd1, 10'd0, 5'd0, 4'd0, 16'd0);
		// Month steps clamp the day.
		push_cmd(OP_LOAD, 16'd0, 10'd0, 5'd31, 4'd1, 16'd2023);
		push_cmd(OP_MONTHS, 16'd1, 10'd0, 5'd0, 4'd0, 16'd0);
		push_cmd(OP_MONTHS, 16'd0, 10'd0, 5'h1F, 4'hF, 16'hFFFF);
		// Year steps from a leap day, with zero and largest strides.
		push_cmd(OP_LOAD, 16'd0, 10'd0, 5'd29, 4'd2, 16'd2024);
		push_cmd(OP_YEARS, 16'd1, 10'd1, 5'd0, 4'd0, 16'd0);
		push_cmd(OP_YEARS, 16'd5, 10'd0, 5'd0, 4'd0, 16'd0);
		push_cmd(OP_YEARS, 16'd3, 10'h3FF, 5'd0, 4'd0, 16'd0);
		// Largest amounts for each kind of step.
		push_cmd(OP_DAYS, 16'hFFFF, 10'd0, 5'd0, 4'd0, 16'd0);
		push_cmd(OP_MONTHS, 16'hFFFF, 10'd0, 5'd0, 4'd0, 16'd0);
		push_cmd(OP_YEARS, 16'hFFFF, 10'd1000, 5'd0, 4'd0, 16'd0);
		push_cmd(OP_LOAD, 16'd0, 10'd0, 5'd1, 4'd1, 16'd0);

		for (n = 0; n < RANDOM_CMDS; n++)
			add_random_cmd();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || in_valid || expected_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* calendar_date_adder_core.f */
hdl/cda_pkg.sv
hdl/calendar_date_adder_core.sv
dv/tb_top.sv
